[hw/rtl/dapph_pkg.sv]
// ----------------------------------------------------------------------------
// dapph_pkg
// Shared widths, register indexes, command codes and types of the dual-axis
// PID position hold block.
// ----------------------------------------------------------------------------
package dapph_pkg;

    // fixed-point formats
    localparam int TIME_FRAC = 10;                    // frame time fraction bits
    localparam int GAIN_FRAC = 12;                    // gain fraction bits
    localparam int FRAC      = TIME_FRAC + GAIN_FRAC; // controller sum fraction bits

    // field widths
    localparam int POS_W      = 16;
    localparam int DT_W       = 16;
    localparam int GAIN_W     = 16;
    localparam int ILIM_W     = 15;
    localparam int OLIM_W     = 9;
    localparam int CMD_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // internal widths
    localparam int ERR_W  = POS_W + 1;                 // setpoint - position
    localparam int DIFF_W = ERR_W + 1;                 // error - last error
    localparam int MAGD_W = ERR_W;                     // |diff| < 2^ERR_W
    localparam int INT_W  = ILIM_W + TIME_FRAC + 2;    // integral state
    localparam int MA_W   = INT_W + 1;                 // multiplier signed operand
    localparam int MB_W   = GAIN_W + 1;                // gain/dt, zero-extended
    localparam int MP_W   = MA_W + MB_W;               // product
    localparam int ASUM_W = ERR_W + DT_W + 2;          // integral + err*dt
    localparam int MAG_W  = MAGD_W + GAIN_W;           // |diff| * gain_d
    localparam int NUM_W  = MAG_W + 2 * TIME_FRAC;     // dividend, quotient
    localparam int SUM_W  = NUM_W + 3;                 // controller sum
    localparam int OX_W   = OLIM_W + 1;                // clamped loop output

    localparam logic [CMD_W-1:0] STICK_MID = CMD_W'(1500);
    localparam logic [SUM_W-1:0] ROUND_MASK = SUM_W'((64'd1 << FRAC) - 64'd1);

    // sequencing
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int STEP_W    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P     = 3'd0,
        REG_GAIN_I     = 3'd1,
        REG_GAIN_D     = 3'd2,
        REG_INT_LIMIT  = 3'd3,
        REG_OUT_LIMIT  = 3'd4,
        REG_SETPOINT_X = 3'd5,
        REG_SETPOINT_Y = 3'd6,
        REG_DEPTH_THR  = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic        [GAIN_W-1:0] gain_p;
        logic        [GAIN_W-1:0] gain_i;
        logic        [GAIN_W-1:0] gain_d;
        logic        [ILIM_W-1:0] integral_limit;
        logic        [OLIM_W-1:0] output_limit;
        logic signed [POS_W-1:0]  setpoint_x;
        logic signed [POS_W-1:0]  setpoint_y;
        logic signed [POS_W-1:0]  depth_threshold;
    } t_cfg;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_ERR,
        OP_MUL,
        OP_DIV,
        OP_ADD_D,
        OP_CLAMP,
        OP_OUT
    } t_op;

    // multiply steps; every step after the first also consumes the product of the step before
    typedef enum logic [STEP_W-1:0] {
        MS_ERR_DT_X  = 4'd0,
        MS_ERR_DT_Y  = 4'd1,
        MS_DIFF_GD_X = 4'd2,
        MS_DIFF_GD_Y = 4'd3,
        MS_ERR_GP_X  = 4'd4,
        MS_ERR_GP_Y  = 4'd5,
        MS_INT_GI_X  = 4'd6,
        MS_INT_GI_Y  = 4'd7,
        MS_LAST      = 4'd8
    } t_mstep;

    typedef struct packed {
        t_op    op;
        t_mstep step;
    } t_cmd;

endpackage

[hw/rtl/dapph_ctrl.sv]
// ----------------------------------------------------------------------------
// dapph_ctrl
// Sequencer: input accept, multiply steps, divide iterations, output register
// valid.
// ----------------------------------------------------------------------------
module dapph_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output dapph_pkg::t_cmd o_cmd
);
    import dapph_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_MUL,
        S_DIV,
        S_ADD_D,
        S_CLAMP,
        S_OUT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    logic             s_out_free;

    assign s_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.op   = OP_NONE;
        o_cmd.step = MS_ERR_DT_X;
        case (r_state)
            S_IDLE:  o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            S_ERR:   o_cmd.op = OP_ERR;
            S_MUL: begin
                o_cmd.op   = OP_MUL;
                o_cmd.step = t_mstep'(r_cnt[STEP_W-1:0]);
            end
            S_DIV:   o_cmd.op = OP_DIV;
            S_ADD_D: o_cmd.op = OP_ADD_D;
            S_CLAMP: o_cmd.op = OP_CLAMP;
            S_OUT:   o_cmd.op = s_out_free ? OP_OUT : OP_NONE;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && s_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_cnt   <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_cnt[STEP_W-1:0] == MS_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_DIV: begin
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_ADD_D;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_ADD_D: r_state <= S_CLAMP;
                S_CLAMP: r_state <= S_OUT;
                S_OUT: begin
                    if (s_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[hw/rtl/dapph_datapath.sv]
// ----------------------------------------------------------------------------
// dapph_datapath
// Two PID lanes around one shared multiplier and two bit-serial dividers,
// plus the result payload register.
// ----------------------------------------------------------------------------
module dapph_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dapph_pkg::t_cmd                     i_cmd,
    input  dapph_pkg::t_cfg                     i_cfg,
    input  logic signed [dapph_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [dapph_pkg::POS_W-1:0]  i_pos_y,
    input  logic signed [dapph_pkg::POS_W-1:0]  i_depth_z,
    input  logic                                i_hold_request,
    input  logic        [dapph_pkg::DT_W-1:0]   i_delta_time,
    output logic        [dapph_pkg::CMD_W-1:0]  o_roll_cmd,
    output logic        [dapph_pkg::CMD_W-1:0]  o_pitch_cmd
);
    import dapph_pkg::*;

    // captured item
    logic signed [POS_W-1:0]  r_pos   [2];
    logic signed [POS_W-1:0]  r_depth;
    logic                     r_hold;
    logic        [DT_W-1:0]   r_dt;

    // per-lane working registers
    logic signed [ERR_W-1:0]  r_err   [2];
    logic        [MAGD_W-1:0] r_dmag  [2];
    logic                     r_dneg  [2];
    logic                     r_neutral;
    logic signed [MP_W-1:0]   r_prod;
    logic signed [INT_W-1:0]  r_integ [2];
    logic signed [ERR_W-1:0]  r_last  [2];
    logic signed [SUM_W-1:0]  r_sum   [2];
    logic        [NUM_W-1:0]  r_quo   [2];
    logic        [DT_W-1:0]   r_rem   [2];
    logic signed [OX_W-1:0]   r_ox    [2];
    logic        [CMD_W-1:0]  r_cmd_out [2];

    logic signed [POS_W-1:0]  s_sp    [2];
    logic signed [ERR_W-1:0]  s_err   [2];
    logic signed [DIFF_W-1:0] s_diff  [2];
    logic signed [DIFF_W-1:0] s_dabs  [2];
    logic signed [MA_W-1:0]   s_ma;
    logic signed [MB_W-1:0]   s_mb;
    logic signed [MP_W-1:0]   s_mul;
    logic signed [SUM_W-1:0]  s_prod_ext;
    logic signed [SUM_W-1:0]  s_pterm;
    logic signed [ASUM_W-1:0] s_ilim;
    logic signed [ASUM_W-1:0] s_asum  [2];
    logic signed [INT_W-1:0]  s_acc   [2];
    logic        [DT_W:0]     s_trial [2];
    logic                     s_ge    [2];
    logic        [DT_W-1:0]   s_rem_n [2];
    logic signed [SUM_W-1:0]  s_q     [2];
    logic signed [SUM_W-1:0]  s_d     [2];
    logic signed [SUM_W-1:0]  s_olim;
    logic signed [SUM_W-1:0]  s_cl    [2];
    logic signed [SUM_W-1:0]  s_trunc [2];
    logic        [CMD_W-1:0]  s_out   [2];

    assign s_sp[0] = i_cfg.setpoint_x;
    assign s_sp[1] = i_cfg.setpoint_y;

    // error and derivative difference
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            s_err[k]  = {s_sp[k][POS_W-1], s_sp[k]} - {r_pos[k][POS_W-1], r_pos[k]};
            s_diff[k] = {s_err[k][ERR_W-1], s_err[k]} - {r_last[k][ERR_W-1], r_last[k]};
            s_dabs[k] = s_diff[k][DIFF_W-1] ? -s_diff[k] : s_diff[k];
        end
    end

    // shared multiplier operand select
    always_comb begin
        s_ma = '0;
        s_mb = '0;
        case (i_cmd.step)
            MS_ERR_DT_X: begin
                s_ma = {{(MA_W-ERR_W){r_err[0][ERR_W-1]}}, r_err[0]};
                s_mb = {1'b0, r_dt};
            end
            MS_ERR_DT_Y: begin
                s_ma = {{(MA_W-ERR_W){r_err[1][ERR_W-1]}}, r_err[1]};
                s_mb = {1'b0, r_dt};
            end
            MS_DIFF_GD_X: begin
                s_ma = {{(MA_W-MAGD_W){1'b0}}, r_dmag[0]};
                s_mb = {1'b0, i_cfg.gain_d};
            end
            MS_DIFF_GD_Y: begin
                s_ma = {{(MA_W-MAGD_W){1'b0}}, r_dmag[1]};
                s_mb = {1'b0, i_cfg.gain_d};
            end
            MS_ERR_GP_X: begin
                s_ma = {{(MA_W-ERR_W){r_err[0][ERR_W-1]}}, r_err[0]};
                s_mb = {1'b0, i_cfg.gain_p};
            end
            MS_ERR_GP_Y: begin
                s_ma = {{(MA_W-ERR_W){r_err[1][ERR_W-1]}}, r_err[1]};
                s_mb = {1'b0, i_cfg.gain_p};
            end
            MS_INT_GI_X: begin
                s_ma = {{(MA_W-INT_W){r_integ[0][INT_W-1]}}, r_integ[0]};
                s_mb = {1'b0, i_cfg.gain_i};
            end
            MS_INT_GI_Y: begin
                s_ma = {{(MA_W-INT_W){r_integ[1][INT_W-1]}}, r_integ[1]};
                s_mb = {1'b0, i_cfg.gain_i};
            end
            default: begin
                s_ma = '0;
                s_mb = '0;
            end
        endcase
    end

    assign s_mul      = s_ma * s_mb;
    assign s_prod_ext = {{(SUM_W-MP_W){r_prod[MP_W-1]}}, r_prod};
    assign s_pterm    = s_prod_ext <<< TIME_FRAC;

    // integral accumulate and clamp
    assign s_ilim = {{(ASUM_W-ILIM_W-TIME_FRAC){1'b0}}, i_cfg.integral_limit,
                     {TIME_FRAC{1'b0}}};

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            s_asum[k] = {{(ASUM_W-INT_W){r_integ[k][INT_W-1]}}, r_integ[k]}
                      + r_prod[ASUM_W-1:0];
            if (s_asum[k] > s_ilim) begin
                s_acc[k] = s_ilim[INT_W-1:0];
            end else if (s_asum[k] < -s_ilim) begin
                s_acc[k] = INT_W'(-s_ilim);
            end else begin
                s_acc[k] = s_asum[k][INT_W-1:0];
            end
        end
    end

    // restoring divide, one quotient bit per lane per cycle
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            s_trial[k] = {r_rem[k], r_quo[k][NUM_W-1]};
            s_ge[k]    = (s_trial[k] >= {1'b0, r_dt});
            s_rem_n[k] = s_ge[k] ? DT_W'(s_trial[k] - {1'b0, r_dt})
                                 : s_trial[k][DT_W-1:0];
        end
    end

    // derivative term, output clamp, truncation toward zero
    assign s_olim = {{(SUM_W-OLIM_W-FRAC){1'b0}}, i_cfg.output_limit, {FRAC{1'b0}}};

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            s_q[k] = {{(SUM_W-NUM_W){1'b0}}, r_quo[k]};
            if (r_dt == '0) begin
                s_d[k] = '0;
            end else begin
                s_d[k] = r_dneg[k] ? -s_q[k] : s_q[k];
            end
            if (r_sum[k] > s_olim) begin
                s_cl[k] = s_olim;
            end else if (r_sum[k] < -s_olim) begin
                s_cl[k] = -s_olim;
            end else begin
                s_cl[k] = r_sum[k];
            end
            if (s_cl[k] < 0) begin
                s_trunc[k] = (s_cl[k] + ROUND_MASK) >>> FRAC;
            end else begin
                s_trunc[k] = s_cl[k] >>> FRAC;
            end
            s_out[k] = r_neutral ? STICK_MID
                     : STICK_MID + {{(CMD_W-OX_W){r_ox[k][OX_W-1]}}, r_ox[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 2; k++) begin
                r_integ[k] <= '0;
                r_last[k]  <= '0;
            end
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_pos[0] <= i_pos_x;
                    r_pos[1] <= i_pos_y;
                    r_depth  <= i_depth_z;
                    r_hold   <= i_hold_request;
                    r_dt     <= i_delta_time;
                end
                OP_ERR: begin
                    for (int k = 0; k < 2; k++) begin
                        r_err[k]  <= s_err[k];
                        r_dmag[k] <= s_dabs[k][MAGD_W-1:0];
                        r_dneg[k] <= s_diff[k][DIFF_W-1];
                    end
                    r_neutral <= r_hold || (r_depth < i_cfg.depth_threshold);
                end
                OP_MUL: begin
                    r_prod <= s_mul;
                    case (i_cmd.step)
                        MS_ERR_DT_Y:  r_integ[0] <= s_acc[0];
                        MS_DIFF_GD_X: r_integ[1] <= s_acc[1];
                        MS_DIFF_GD_Y: begin
                            r_quo[0] <= {r_prod[MAG_W-1:0], {(2*TIME_FRAC){1'b0}}};
                            r_rem[0] <= '0;
                        end
                        MS_ERR_GP_X: begin
                            r_quo[1] <= {r_prod[MAG_W-1:0], {(2*TIME_FRAC){1'b0}}};
                            r_rem[1] <= '0;
                        end
                        MS_ERR_GP_Y:  r_sum[0] <= s_pterm;
                        MS_INT_GI_X:  r_sum[1] <= s_pterm;
                        MS_INT_GI_Y:  r_sum[0] <= r_sum[0] + s_prod_ext;
                        MS_LAST:      r_sum[1] <= r_sum[1] + s_prod_ext;
                        default: ;
                    endcase
                end
                OP_DIV: begin
                    for (int k = 0; k < 2; k++) begin
                        r_rem[k] <= s_rem_n[k];
                        r_quo[k] <= {r_quo[k][NUM_W-2:0], s_ge[k]};
                    end
                end
                OP_ADD_D: begin
                    for (int k = 0; k < 2; k++) begin
                        r_sum[k] <= r_sum[k] + s_d[k];
                    end
                end
                OP_CLAMP: begin
                    for (int k = 0; k < 2; k++) begin
                        r_ox[k] <= s_trunc[k][OX_W-1:0];
                    end
                end
                OP_OUT: begin
                    for (int k = 0; k < 2; k++) begin
                        r_cmd_out[k] <= s_out[k];
                        r_last[k]    <= r_err[k];
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_roll_cmd  = r_cmd_out[0];
    assign o_pitch_cmd = r_cmd_out[1];

endmodule

[hw/rtl/dual_axis_pid_position_hold.sv]
// ----------------------------------------------------------------------------
// dual_axis_pid_position_hold
// Two PID loops with shared gains turn a tracked target position into roll
// and pitch stick commands around mid-stick 1500.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one frame item: pos_x,
//   pos_y, depth_z, hold_request and delta_time. Output channel
//   (o_out_valid / i_out_stall) carries one result item per input item:
//   roll_cmd and pitch_cmd. The config channel (i_cfg_valid / o_cfg_ready)
//   writes gains, limits, setpoints and the depth threshold by index; it is
//   always ready and is meant to be written while no item is in flight.
//   From input accept to o_out_valid an item passes an error step,
//   9 steps through the one shared multiplier, 53 iterations of the
//   bit-serial derivative dividers (one quotient bit a cycle, x and y lanes
//   in parallel), then derivative add, clamp and output load.
//   One item at a time: the next item is taken only in the cycle after the
//   result is loaded, even while that result is stalled.
//   A stalled result holds in the output register; a second result waits
//   in the last step until the register frees up.
//   Reset (synchronous, active low) clears the integrals, last errors and
//   sequencer, and loads the register defaults. No clearing pass.
// ----------------------------------------------------------------------------
module dual_axis_pid_position_hold (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // input items
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [dapph_pkg::POS_W-1:0]      i_pos_x,
    input  logic signed [dapph_pkg::POS_W-1:0]      i_pos_y,
    input  logic signed [dapph_pkg::POS_W-1:0]      i_depth_z,
    input  logic                                    i_hold_request,
    input  logic        [dapph_pkg::DT_W-1:0]       i_delta_time,
    // result items
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic        [dapph_pkg::CMD_W-1:0]      o_roll_cmd,
    output logic        [dapph_pkg::CMD_W-1:0]      o_pitch_cmd,
    // configuration writes
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic        [dapph_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [dapph_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dapph_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    t_cmd s_cmd;

    // register file: always ready, bits above a field's width are dropped
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_GAIN_P:     n_cfg.gain_p          = i_cfg_data;
                REG_GAIN_I:     n_cfg.gain_i          = i_cfg_data;
                REG_GAIN_D:     n_cfg.gain_d          = i_cfg_data;
                REG_INT_LIMIT:  n_cfg.integral_limit  = i_cfg_data[ILIM_W-1:0];
                REG_OUT_LIMIT:  n_cfg.output_limit    = i_cfg_data[OLIM_W-1:0];
                REG_SETPOINT_X: n_cfg.setpoint_x      = i_cfg_data;
                REG_SETPOINT_Y: n_cfg.setpoint_y      = i_cfg_data;
                REG_DEPTH_THR:  n_cfg.depth_threshold = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p          <= GAIN_W'(1393);
            r_cfg.gain_i          <= '0;
            r_cfg.gain_d          <= GAIN_W'(819);
            r_cfg.integral_limit  <= ILIM_W'(200);
            r_cfg.output_limit    <= OLIM_W'(50);
            r_cfg.setpoint_x      <= '0;
            r_cfg.setpoint_y      <= '0;
            r_cfg.depth_threshold <= POS_W'(20);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // sequencer: owns the input and output handshakes and drives one command per cycle
    dapph_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (s_cmd)
    );

    // both PID lanes, the shared multiplier, dividers and result register
    dapph_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (s_cmd),
        .i_cfg          (r_cfg),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_depth_z      (i_depth_z),
        .i_hold_request (i_hold_request),
        .i_delta_time   (i_delta_time),
        .o_roll_cmd     (o_roll_cmd),
        .o_pitch_cmd    (o_pitch_cmd)
    );

    // accepted item makes the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // result register is only loaded when it is empty or being drained
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_cmd.op == OP_OUT) |-> (!o_out_valid || !i_out_stall))
        else $error("pending result overwritten");

    // no result can show up the cycle right after an accept
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_in_valid && !o_in_stall && !o_out_valid) |=> !o_out_valid)
        else $error("result valid too early");

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for dual_axis_pid_position_hold. It drives frame items with random
// gaps and stalls the results at random. A built-in model of both PID loops
// predicts the roll and pitch commands, and a scoreboard compares them with
// the results in order. Several register settings are applied between phases,
// the extremes among them.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dapph_pkg::*;

    localparam int RESET_CYCLES    = 10;
    localparam int MAX_WAIT        = 18;    // longest per-item idle on either side
    localparam int HOLD_OFF_CYCLES = 500;   // long receiver hold-off, fills the block
    localparam int DRAIN_CYCLES    = 100;   // longer than the block's latency, catches strays
    localparam int WATCHDOG_LIMIT  = 4000;  // cycles with no item moving on any channel

    // one frame item as the block takes it
    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] depth_z;
        logic                    hold_request;
        logic        [DT_W-1:0]  delta_time;
    } t_frame;

    // one result item
    typedef struct packed {
        logic [CMD_W-1:0] roll;
        logic [CMD_W-1:0] pitch;
    } t_stick_pair;

    localparam t_cfg RESET_SETTINGS =
        t_cfg'{16'd1393, 16'd0, 16'd819, 15'd200, 9'd50, 16'sd0, 16'sd0, 16'sd20};

    // ------------------------------------------------------------------------
    // Scoreboard: a bit-exact model of both loops plus the queue of stick
    // commands it predicts.
    // ------------------------------------------------------------------------
    class stick_scoreboard;
        t_cfg                    regs;
        logic signed [INT_W-1:0] integ_x, integ_y;
        logic signed [ERR_W-1:0] last_err_x, last_err_y;
        t_stick_pair             expected_sticks[$];
        int                      mismatches;
        int                      compared;

        function new();
            regs       = RESET_SETTINGS;
            integ_x    = '0;
            integ_y    = '0;
            last_err_x = '0;
            last_err_y = '0;
            mismatches = 0;
            compared   = 0;
        endfunction

        // bits beyond a register's width are dropped
        function void set_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GAIN_P:     regs.gain_p          = data;
                REG_GAIN_I:     regs.gain_i          = data;
                REG_GAIN_D:     regs.gain_d          = data;
                REG_INT_LIMIT:  regs.integral_limit  = data[ILIM_W-1:0];
                REG_OUT_LIMIT:  regs.output_limit    = data[OLIM_W-1:0];
                REG_SETPOINT_X: regs.setpoint_x      = data;
                REG_SETPOINT_Y: regs.setpoint_y      = data;
                REG_DEPTH_THR:  regs.depth_threshold = data;
                default: ;
            endcase
        endfunction

        // one loop; returns the clamped output in whole stick units
        function longint axis_correction(longint setpoint, longint pos, longint dt,
                                         inout logic signed [INT_W-1:0] integ,
                                         inout logic signed [ERR_W-1:0] last_err);
            longint err, acc, ilim, olim, diff, mag, dterm, sum;
            err  = setpoint - pos;
            ilim = longint'(regs.integral_limit) <<< TIME_FRAC;
            olim = longint'(regs.output_limit) <<< FRAC;
            acc  = longint'(integ) + err * dt;
            if (acc > ilim) acc = ilim;
            if (acc < -ilim) acc = -ilim;
            integ = INT_W'(acc);
            // |diff| * gain_d * 2^20 stays below 2^54: no saturation reachable
            dterm = 0;
            if (dt != 0) begin
                diff  = err - longint'(last_err);
                mag   = (diff < 0 ? -diff : diff) * longint'(regs.gain_d);
                dterm = (mag <<< (2 * TIME_FRAC)) / dt;
                if (diff < 0) dterm = -dterm;
            end
            last_err = ERR_W'(err);
            sum = ((longint'(regs.gain_p) * err) <<< TIME_FRAC)
                + longint'(regs.gain_i) * acc + dterm;
            if (sum > olim) sum = olim;
            if (sum < -olim) sum = -olim;
            return sum / (longint'(1) <<< FRAC);   // truncates toward zero
        endfunction

        function void note_frame(t_frame f);
            longint      dx, dy;
            t_stick_pair want;
            dx = axis_correction(longint'($signed(regs.setpoint_x)), longint'($signed(f.pos_x)),
                                 longint'(f.delta_time), integ_x, last_err_x);
            dy = axis_correction(longint'($signed(regs.setpoint_y)), longint'($signed(f.pos_y)),
                                 longint'(f.delta_time), integ_y, last_err_y);
            // neutral sticks, loop state already updated above
            if (f.hold_request || $signed(f.depth_z) < $signed(regs.depth_threshold)) begin
                dx = 0;
                dy = 0;
            end
            want.roll  = CMD_W'(longint'(STICK_MID) + dx);
            want.pitch = CMD_W'(longint'(STICK_MID) + dy);
            expected_sticks.push_back(want);
        endfunction

        function void check_sticks(t_stick_pair got);
            t_stick_pair want;
            if (expected_sticks.size() == 0) begin
                $display("%0t: unexpected result roll=%0d pitch=%0d", $time, got.roll, got.pitch);
                mismatches++;
                return;
            end
            want = expected_sticks.pop_front();
            compared++;
            if (got.roll !== want.roll) begin
                $display("%0t: roll_cmd expected %0d actual %0d", $time, want.roll, got.roll);
                mismatches++;
            end
            if (got.pitch !== want.pitch) begin
                $display("%0t: pitch_cmd expected %0d actual %0d", $time, want.pitch, got.pitch);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_sticks.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                        i_clk          = 1'b0;
    logic                        i_rst_n        = 1'b0;
    logic                        i_in_valid     = 1'b0;
    logic                        o_in_stall;
    logic signed [POS_W-1:0]     i_pos_x        = '0;
    logic signed [POS_W-1:0]     i_pos_y        = '0;
    logic signed [POS_W-1:0]     i_depth_z      = '0;
    logic                        i_hold_request = 1'b0;
    logic        [DT_W-1:0]      i_delta_time   = '0;
    logic                        o_out_valid;
    logic                        i_out_stall    = 1'b0;
    logic        [CMD_W-1:0]     o_roll_cmd;
    logic        [CMD_W-1:0]     o_pitch_cmd;
    logic                        i_cfg_valid    = 1'b0;
    logic                        o_cfg_ready;
    logic        [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic        [CFG_DATA_W-1:0] i_cfg_data    = '0;

    stick_scoreboard sb = new();

    int send_run        = 0;   // items left in a no-gap stretch, sender
    int recv_run        = 0;   // same, receiver
    int frames_sent     = 0;
    int results_seen    = 0;
    int hold_offs       = 0;
    int settings_loaded = 0;

    dual_axis_pid_position_hold DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_depth_z      (i_depth_z),
        .i_hold_request (i_hold_request),
        .i_delta_time   (i_delta_time),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_roll_cmd     (o_roll_cmd),
        .o_pitch_cmd    (o_pitch_cmd),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 20 ns clock
    always #10 i_clk = ~i_clk;

    // Per-item idle draw, 0..MAX_WAIT. Now and then a stretch of items with
    // no idling at all starts.
    function automatic int draw_wait(ref int run);
        if (run > 0) begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) run = int'($urandom_range(5, 25));
        return int'($urandom_range(0, MAX_WAIT));
    endfunction

    function automatic logic signed [POS_W-1:0] sat16(int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return POS_W'(v);
    endfunction

    // Random frame. Most are tracking frames near the setpoint with small
    // frame times, so the loops leave the clamps and the integral builds up.
    // The rest: fully random fields, zero frame time, hold, shallow depth.
    function automatic t_frame pick_frame();
        t_frame f;
        int     kind, spread, thr, sx, sy;
        kind = int'($urandom_range(0, 99));
        thr  = int'($signed(sb.regs.depth_threshold));
        sx   = int'($signed(sb.regs.setpoint_x));
        sy   = int'($signed(sb.regs.setpoint_y));
        if (kind < 15) begin
            f.pos_x        = POS_W'($urandom);
            f.pos_y        = POS_W'($urandom);
            f.depth_z      = POS_W'($urandom);
            f.hold_request = 1'($urandom);
            f.delta_time   = DT_W'($urandom);
            return f;
        end
        case ($urandom_range(0, 3))
            0:       spread = 5000;
            1:       spread = 8;
            default: spread = 300;
        endcase
        f.pos_x        = sat16(sx + int'($urandom_range(0, 2 * spread)) - spread);
        f.pos_y        = sat16(sy + int'($urandom_range(0, 2 * spread)) - spread);
        f.depth_z      = POS_W'(thr + int'($urandom_range(0, 32767 - thr)));
        f.hold_request = ($urandom_range(0, 19) == 0);
        f.delta_time   = ($urandom_range(0, 7) == 0) ? DT_W'($urandom)
                                                     : DT_W'($urandom_range(1, 200));
        if (kind < 25)
            f.delta_time = '0;
        else if (kind < 35)
            f.hold_request = 1'b1;
        else if (kind < 45 && thr > -32768)
            f.depth_z = POS_W'(thr - 1 - int'($urandom_range(0, thr + 32767)));
        return f;
    endfunction

    function automatic t_cfg random_settings();
        t_cfg c;
        c.gain_p          = GAIN_W'($urandom_range(0, 12000));
        c.gain_i          = GAIN_W'($urandom_range(0, 3000));
        c.gain_d          = GAIN_W'($urandom_range(0, 6000));
        c.integral_limit  = ILIM_W'($urandom_range(0, 2000));
        c.output_limit    = OLIM_W'($urandom_range(0, 500));
        c.setpoint_x      = POS_W'(int'($urandom_range(0, 2000)) - 1000);
        c.setpoint_y      = POS_W'(int'($urandom_range(0, 2000)) - 1000);
        c.depth_threshold = POS_W'(int'($urandom_range(0, 400)) - 200);
        return c;
    endfunction

    // One frame item. Valid stays high into the next item when that one has
    // no gap, so valid never drops and rises in the same step.
    task automatic send_frame(t_frame f);
        int gap;
        gap = draw_wait(send_run);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_pos_x        <= f.pos_x;
        i_pos_y        <= f.pos_y;
        i_depth_z      <= f.depth_z;
        i_hold_request <= f.hold_request;
        i_delta_time   <= f.delta_time;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_frame(f);
        frames_sent++;
    endtask

    // Caller lowers i_cfg_valid after the last write of a batch.
    task automatic cfg_write(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
    endtask

    // Limits get random junk above their width; it must be dropped.
    task automatic apply_settings(t_cfg c);
        cfg_write(REG_GAIN_P,     c.gain_p);
        cfg_write(REG_GAIN_I,     c.gain_i);
        cfg_write(REG_GAIN_D,     c.gain_d);
        cfg_write(REG_INT_LIMIT,  {1'($urandom), c.integral_limit});
        cfg_write(REG_OUT_LIMIT,  {7'($urandom), c.output_limit});
        cfg_write(REG_SETPOINT_X, c.setpoint_x);
        cfg_write(REG_SETPOINT_Y, c.setpoint_y);
        cfg_write(REG_DEPTH_THR,  c.depth_threshold);
        i_cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    // Block idle: every expected result back. Each frame gives exactly one
    // result, so the block is idle then; spare cycles follow before a register write.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: stall each result for a drawn number of cycles; twice, hold
    // off for a long stretch so the block fills up and stalls its input.
    // ------------------------------------------------------------------------
    initial begin
        int out_wait;
        int hold_left;
        out_wait  = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                sb.check_sticks(t_stick_pair'{o_roll_cmd, o_pitch_cmd});
                results_seen++;
                out_wait = draw_wait(recv_run);
                if (results_seen == 50 || results_seen == 400) begin
                    hold_left = HOLD_OFF_CYCLES;
                    hold_offs++;
                end
            end else if (o_out_valid && out_wait > 0) begin
                out_wait--;
            end
            if (hold_left > 0) hold_left--;
            i_out_stall <= (out_wait > 0) || (hold_left > 0);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: counts cycles in which no item moves on any channel.
    // ------------------------------------------------------------------------
    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: timeout, no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[dual_axis_pid_position_hold] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int phase_items;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset settings first: depth at and just below threshold,
        // hold, zero frame time, widest frame time.
        send_frame(t_frame'{16'sd0, 16'sd0, 16'sd100, 1'b0, 16'd1024});
        send_frame(t_frame'{16'sd10, -16'sd10, 16'sd20, 1'b0, 16'd1024});
        send_frame(t_frame'{-16'sd5, 16'sd5, 16'sd19, 1'b0, 16'd512});
        send_frame(t_frame'{16'sd3, -16'sd3, 16'sd100, 1'b1, 16'd256});
        send_frame(t_frame'{16'sd7, 16'sd7, 16'sd100, 1'b0, 16'd0});
        send_frame(t_frame'{-16'sd40, 16'sd40, 16'sh7FFF, 1'b0, 16'hFFFF});

        // Largest I and D gains and integral limit, setpoints at opposite extremes,
        // lowest threshold: largest errors, derivative over a one-tick frame.
        settle();
        apply_settings(t_cfg'{16'd4096, 16'hFFFF, 16'hFFFF, 15'h7FFF, 9'd500,
                              16'sh7FFF, 16'sh8000, 16'sh8000});
        send_frame(t_frame'{16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0, 16'hFFFF});
        send_frame(t_frame'{16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0, 16'd1});
        send_frame(t_frame'{16'sh8000, 16'sh7FFF, 16'sd0, 1'b0, 16'd0});
        send_frame(t_frame'{16'sh8000, 16'sh7FFF, 16'sd0, 1'b1, 16'hFFFF});
        send_frame(t_frame'{16'sd0, 16'sd0, 16'sh8000, 1'b0, 16'h8000});

        // Proportional only, widest output clamp, highest threshold.
        settle();
        apply_settings(t_cfg'{16'hFFFF, 16'd0, 16'd0, 15'd0, 9'h1FF,
                              16'sd0, 16'sd0, 16'sh7FFF});
        send_frame(t_frame'{16'sd1, -16'sd1, 16'sh7FFF, 1'b0, 16'd100});
        send_frame(t_frame'{16'sd1, -16'sd1, 16'sh7FFE, 1'b0, 16'd100});
        send_frame(t_frame'{-16'sd1, 16'sd1, 16'sh7FFF, 1'b0, 16'hFFFF});
        send_frame(t_frame'{16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0, 16'd1});

        // Smallest nonzero settings; alternating bit patterns on the fields.
        settle();
        apply_settings(t_cfg'{16'd1, 16'd1, 16'd1, 15'd1, 9'd1,
                              -16'sd1, 16'sd1, 16'sh8000});
        send_frame(t_frame'{16'sh5555, 16'shAAAA, 16'sd0, 1'b0, 16'hFFFF});
        send_frame(t_frame'{16'shAAAA, 16'sh5555, 16'sh7FFF, 1'b1, 16'h5555});
        send_frame(t_frame'{-16'sd1, 16'sd1, 16'sd0, 1'b0, 16'd1});

        // Random phases, each under its own settings.
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0: begin   // near reset values, integral on
                    apply_settings(t_cfg'{16'd1393, 16'd400, 16'd819, 15'd200, 9'd50,
                                          16'sd0, 16'sd0, 16'sd20});
                    phase_items = 110;
                end
                1: begin   // gains and limits at the top, setpoints at opposite extremes, lowest threshold
                    apply_settings(t_cfg'{16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 9'h1FF,
                                          16'sh7FFF, 16'sh8000, 16'sh8000});
                    phase_items = 100;
                end
                2: begin   // gains and limits at zero, setpoints at opposite extremes, threshold at the top
                    apply_settings(t_cfg'{16'd0, 16'd0, 16'd0, 15'd0, 9'd0,
                                          16'sh8000, 16'sh7FFF, 16'sh7FFF});
                    phase_items = 60;
                end
                default: begin
                    apply_settings(random_settings());
                    phase_items = (ph == 5) ? 120 : 130;
                end
            endcase
            repeat (phase_items) send_frame(pick_frame());
        end

        // drain, then a margin past the latency for anything extra
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d frames under %0d register settings, %0d results compared.",
                 frames_sent, settings_loaded, sb.compared);
        $display("Included zero frame time, hold, shallow depth, clamps and %0d long hold-offs.",
                 hold_offs);
        if (sb.mismatches == 0)
            $display("[dual_axis_pid_position_hold] OK");
        else
            $display("[dual_axis_pid_position_hold] ERROR");
        $finish;
    end

endmodule
